@@ design/ptwg_pkg.sv @@
// Shared types, constants and register map for the periodic time window gate.
`default_nettype none

package ptwg_pkg;

    localparam int TS_W      = 63;
    localparam int MS_W      = 44;
    localparam int T_W       = MS_W + 1;
    localparam int PH_W      = 32;
    localparam int LVL_W     = 7;
    localparam int REM_W     = 20;
    localparam int QR_W      = REM_W + 1;
    localparam int MUL_W     = 32;
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;
    localparam int DIV_STEPS = 5;
    localparam int DCNT_W    = $clog2(DIV_STEPS);
    localparam int MCNT_W    = $clog2(PH_W);
    localparam int CMD_QDEPTH = 4;

    localparam logic [REM_W-1:0] NS_PER_MS = REM_W'(1000000);
    // floor(2^63 / 1000000); the product with a timestamp is off by at most one
    localparam logic [MS_W-1:0]  MS_RECIP  = 44'd9223372036854;

    localparam logic [PH_W-1:0]  START_RST    = '0;
    localparam logic [PH_W-1:0]  INTERVAL_RST = '0;
    localparam logic [PH_W-1:0]  DURATION_RST = '0;
    localparam logic [PH_W-1:0]  END_RST      = '0;
    localparam logic             END_EN_RST   = 1'b0;
    localparam logic             NORM_RST     = 1'b1;
    localparam logic [LVL_W-1:0] LVL_IN_RST   = LVL_W'(100);
    localparam logic [LVL_W-1:0] LVL_OUT_RST  = '0;

    typedef enum logic [2:0] {
        REG_START    = 3'd0,
        REG_INTERVAL = 3'd1,
        REG_DURATION = 3'd2,
        REG_END      = 3'd3,
        REG_END_EN   = 3'd4,
        REG_NORM     = 3'd5,
        REG_LVL_IN   = 3'd6,
        REG_LVL_OUT  = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [PH_W-1:0]  start_ms;
        logic [PH_W-1:0]  interval_ms;
        logic [PH_W-1:0]  duration_ms;
        logic [PH_W-1:0]  end_ms;
        logic             end_enable;
        logic             normalize_time;
        logic [LVL_W-1:0] level_in;
        logic [LVL_W-1:0] level_out;
    } t_cfg;

    typedef struct packed {
        logic [TS_W-1:0] ts;
        logic            in_win;
        logic [PH_W-1:0] phase;
    } t_cmd;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_DIV,
        FR_NORM,
        FR_CLASS
    } t_fr_state;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MOD,
        BK_EMIT
    } t_bk_state;

endpackage

`default_nettype wire

@@ design/ptwg_front.sv @@
// Front end: ns-to-ms divide, time normalization and window classification.
`default_nettype none

module ptwg_front (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire ptwg_pkg::t_cfg               i_cfg,
    input  wire logic                         i_push,
    input  wire logic [ptwg_pkg::TS_W-1:0]    i_timestamp_ns,
    output logic                              o_full,
    output logic                              o_cmd_push,
    output ptwg_pkg::t_cmd                    o_cmd,
    input  wire logic                         i_cmd_full
);
    import ptwg_pkg::*;

    localparam logic [DCNT_W-1:0] DIV_LAST = DCNT_W'(DIV_STEPS - 1);
    localparam logic [DCNT_W-1:0] STEP_LL  = DCNT_W'(0);
    localparam logic [DCNT_W-1:0] STEP_LH  = DCNT_W'(1);
    localparam logic [DCNT_W-1:0] STEP_HL  = DCNT_W'(2);
    localparam logic [DCNT_W-1:0] STEP_HH  = DCNT_W'(3);

    t_fr_state          r_state, n_state;
    logic [TS_W-1:0]    r_ts;
    logic [MS_W-1:0]    r_quo;
    logic [2*MUL_W-1:0] r_acc;
    logic [DCNT_W-1:0]  r_cnt;
    logic [T_W-1:0]     r_t;
    logic [MS_W-1:0]    r_first;
    logic               r_first_seen;

    logic [MUL_W-1:0]   w_ma;
    logic [MUL_W-1:0]   w_mb;
    logic [2*MUL_W-1:0] w_prod;
    logic [MS_W-2:0]    w_q0_hi;
    logic [QR_W-1:0]    w_qrem;
    logic               w_fix;
    logic [MS_W-1:0]    w_ms;
    logic [MS_W-1:0]    w_first_eff;
    logic [T_W-1:0]     w_start;
    logic [T_W-1:0]     w_end;
    logic [T_W-1:0]     w_diff;
    logic               w_before;
    logic               w_after;
    logic               w_accept;

    // one 32x32 multiplier: four partial products of ts * MS_RECIP, then q0 * 1e6
    always_comb begin
        unique case (r_cnt)
            STEP_LL: begin
                w_ma = r_ts[MUL_W-1:0];
                w_mb = MS_RECIP[MUL_W-1:0];
            end
            STEP_LH: begin
                w_ma = r_ts[MUL_W-1:0];
                w_mb = MUL_W'(MS_RECIP[MS_W-1:MUL_W]);
            end
            STEP_HL: begin
                w_ma = MUL_W'(r_ts[TS_W-1:MUL_W]);
                w_mb = MS_RECIP[MUL_W-1:0];
            end
            STEP_HH: begin
                w_ma = MUL_W'(r_ts[TS_W-1:MUL_W]);
                w_mb = MUL_W'(MS_RECIP[MS_W-1:MUL_W]);
            end
            default: begin
                w_ma = MUL_W'(r_quo[QR_W-1:0]);
                w_mb = MUL_W'(NS_PER_MS);
            end
        endcase
    end

    assign w_prod      = (2*MUL_W)'(w_ma) * (2*MUL_W)'(w_mb);
    assign w_q0_hi     = (MS_W-1)'(r_acc[2*MUL_W-1:MUL_W]) + w_prod[MS_W-2:0];
    // remainder of the estimate lies in [0, 2e6), so its low 21 bits are exact
    assign w_qrem      = r_ts[QR_W-1:0] - w_prod[QR_W-1:0];
    assign w_fix       = w_qrem >= {1'b0, NS_PER_MS};
    assign w_ms        = r_quo;
    assign w_first_eff = r_first_seen ? r_first : w_ms;
    assign w_start     = T_W'(i_cfg.start_ms);
    assign w_end       = T_W'(i_cfg.end_ms);
    assign w_diff      = r_t - w_start;
    assign w_before    = $signed(r_t) < $signed(w_start);
    assign w_after     = i_cfg.end_enable && ($signed(r_t) >= $signed(w_end));
    assign w_accept    = i_push && !o_full;

    always_comb begin
        n_state    = r_state;
        o_full     = 1'b1;
        o_cmd_push = 1'b0;
        o_cmd.ts     = r_ts;
        o_cmd.in_win = !w_before && !w_after;
        o_cmd.phase  = (|w_diff[T_W-1:PH_W]) ? '1 : w_diff[PH_W-1:0];
        unique case (r_state)
            FR_IDLE: begin
                o_full = 1'b0;
                if (i_push) begin
                    n_state = FR_DIV;
                end
            end
            FR_DIV: begin
                if (r_cnt == DIV_LAST) begin
                    n_state = FR_NORM;
                end
            end
            FR_NORM: begin
                n_state = FR_CLASS;
            end
            FR_CLASS: begin
                if (!i_cmd_full) begin
                    o_cmd_push = 1'b1;
                    n_state    = FR_IDLE;
                end
            end
            default: n_state = FR_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FR_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_seen <= 1'b0;
            r_first      <= '0;
        end else if (r_state == FR_NORM && !r_first_seen) begin
            r_first_seen <= 1'b1;
            r_first      <= w_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ts  <= i_timestamp_ns;
            r_cnt <= '0;
        end else if (r_state == FR_DIV) begin
            r_cnt <= r_cnt + 1'b1;
            unique case (r_cnt)
                STEP_LL: begin
                    r_acc <= (2*MUL_W)'(w_prod[2*MUL_W-1:MUL_W]);
                end
                STEP_LH, STEP_HL: begin
                    r_acc <= r_acc + w_prod;
                end
                STEP_HH: begin
                    r_quo <= {w_q0_hi, r_acc[MUL_W-1]};
                end
                default: begin
                    r_quo <= r_quo + MS_W'(w_fix);
                end
            endcase
        end
        if (r_state == FR_NORM) begin
            r_t <= {1'b0, w_ms} - (i_cfg.normalize_time ? {1'b0, w_first_eff} : '0);
        end
    end

endmodule

`default_nettype wire

@@ design/ptwg_fifo.sv @@
// Small word queue between the front and back ends.
`default_nettype none

module ptwg_fifo #(
    parameter int DEPTH = ptwg_pkg::CMD_QDEPTH
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire ptwg_pkg::t_cmd  i_data,
    output logic                 o_full,
    input  wire logic            i_pop,
    output ptwg_pkg::t_cmd       o_data,
    output logic                 o_empty
);
    import ptwg_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    t_cmd            r_mem [DEPTH];
    logic [AW-1:0]   r_wr, r_rd;
    logic [CW-1:0]   r_cnt;
    logic            w_do_push, w_do_pop;

    assign o_full    = r_cnt == CNT_FULL;
    assign o_empty   = r_cnt == '0;
    assign o_data    = r_mem[r_rd];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_do_push) begin
                r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_do_pop && !w_do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

@@ design/ptwg_back.sv @@
// Back end: phase modulo, level decision and result register.
`default_nettype none

module ptwg_back (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire ptwg_pkg::t_cfg               i_cfg,
    input  wire ptwg_pkg::t_cmd               i_cmd,
    input  wire logic                         i_cmd_empty,
    output logic                              o_cmd_pop,
    input  wire logic                         i_pop,
    output logic                              o_empty,
    output logic [ptwg_pkg::LVL_W-1:0]        o_interest,
    output logic [ptwg_pkg::TS_W-1:0]         o_timestamp_echo
);
    import ptwg_pkg::*;

    localparam logic [MCNT_W-1:0] MOD_LAST = MCNT_W'(PH_W - 1);

    t_bk_state          r_state, n_state;
    logic [TS_W-1:0]    r_ts;
    logic               r_in_win;
    logic [PH_W-1:0]    r_ph;
    logic [PH_W-1:0]    r_rem;
    logic [MCNT_W-1:0]  r_cnt;
    logic [PH_W-1:0]    r_last_phase;
    logic               r_last_vld;
    logic               r_out_vld;
    logic [LVL_W-1:0]   r_out_lvl;
    logic [TS_W-1:0]    r_out_ts;

    logic [PH_W:0]      w_trial;
    logic               w_ge;
    logic [PH_W:0]      w_sub;
    logic               w_ival_zero;
    logic               w_emit;
    logic               w_hit;
    logic [LVL_W-1:0]   w_lvl;

    assign w_trial     = {r_rem, r_ph[PH_W-1]};
    assign w_ge        = w_trial >= {1'b0, i_cfg.interval_ms};
    assign w_sub       = w_trial - {1'b0, i_cfg.interval_ms};
    assign w_ival_zero = i_cfg.interval_ms == '0;

    always_comb begin
        if (!r_in_win) begin
            w_hit = 1'b0;
        end else if (i_cfg.duration_ms == '0) begin
            w_hit = w_ival_zero || !r_last_vld || (r_rem < r_last_phase);
        end else begin
            w_hit = r_rem < i_cfg.duration_ms;
        end
        w_lvl = w_hit ? i_cfg.level_in : i_cfg.level_out;
    end

    always_comb begin
        n_state   = r_state;
        o_cmd_pop = 1'b0;
        w_emit    = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                if (!i_cmd_empty) begin
                    o_cmd_pop = 1'b1;
                    n_state   = (i_cmd.in_win && !w_ival_zero) ? BK_MOD : BK_EMIT;
                end
            end
            BK_MOD: begin
                if (r_cnt == MOD_LAST) begin
                    n_state = BK_EMIT;
                end
            end
            BK_EMIT: begin
                if (!r_out_vld || i_pop) begin
                    w_emit  = 1'b1;
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld    <= 1'b0;
            r_last_vld   <= 1'b0;
            r_last_phase <= '0;
        end else begin
            if (w_emit) begin
                r_out_vld <= 1'b1;
            end else if (i_pop) begin
                r_out_vld <= 1'b0;
            end
            if (w_emit && r_in_win) begin
                r_last_vld   <= 1'b1;
                r_last_phase <= r_rem;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_ts     <= i_cmd.ts;
            r_in_win <= i_cmd.in_win;
            r_ph     <= i_cmd.phase;
            r_rem    <= w_ival_zero ? i_cmd.phase : '0;
            r_cnt    <= '0;
        end else if (r_state == BK_MOD) begin
            r_ph  <= {r_ph[PH_W-2:0], 1'b0};
            r_rem <= w_ge ? w_sub[PH_W-1:0] : w_trial[PH_W-1:0];
            r_cnt <= r_cnt + 1'b1;
        end
        if (w_emit) begin
            r_out_lvl <= w_lvl;
            r_out_ts  <= r_ts;
        end
    end

    assign o_empty          = !r_out_vld;
    assign o_interest       = r_out_lvl;
    assign o_timestamp_echo = r_out_ts;

endmodule

`default_nettype wire

@@ design/periodic_time_window_gate.sv @@
// Periodic time window gate: top level with configuration registers.
//
// Each frame timestamp (ns) is turned into whole milliseconds, optionally made relative
// to the first frame, and mapped to an interest level: level_out outside [start, end)
// (end only when end_enable is set), otherwise level_in while the phase (time since
// start, modulo interval when nonzero) is below duration; a zero duration marks the first
// in-window frame and each wrap, or every in-window frame when interval is zero. One
// result word per input word, in order. The front end does a 5-step reciprocal multiply
// on one 32x32 multiplier for the ns-to-ms divide, then normalizes and classifies; the
// back end's 32-step phase modulo, when it runs, sets the sustained rate. A small queue
// between them and a result register let the next word enter while a result waits to be
// popped. Registers sit at byte address 4*index; write only while the block is idle.
`default_nettype none

module periodic_time_window_gate #(
    parameter int Q_DEPTH = ptwg_pkg::CMD_QDEPTH
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [ptwg_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [ptwg_pkg::DATA_W-1:0]   pwdata,
    output logic [ptwg_pkg::DATA_W-1:0]        prdata,
    output logic                               pready,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic [ptwg_pkg::TS_W-1:0]     i_timestamp_ns,
    output logic                               empty,
    input  wire logic                          pop,
    output logic [ptwg_pkg::LVL_W-1:0]         o_interest,
    output logic [ptwg_pkg::TS_W-1:0]          o_timestamp_echo
);
    import ptwg_pkg::*;

    t_cfg       r_cfg;
    t_reg_idx   w_idx;
    logic       w_wr;
    logic       w_cmd_push, w_cmd_full, w_cmd_pop, w_cmd_empty;
    t_cmd       w_cmd_in, w_cmd_out;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_ms       <= START_RST;
            r_cfg.interval_ms    <= INTERVAL_RST;
            r_cfg.duration_ms    <= DURATION_RST;
            r_cfg.end_ms         <= END_RST;
            r_cfg.end_enable     <= END_EN_RST;
            r_cfg.normalize_time <= NORM_RST;
            r_cfg.level_in       <= LVL_IN_RST;
            r_cfg.level_out      <= LVL_OUT_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_START:    r_cfg.start_ms       <= pwdata[PH_W-1:0];
                REG_INTERVAL: r_cfg.interval_ms    <= pwdata[PH_W-1:0];
                REG_DURATION: r_cfg.duration_ms    <= pwdata[PH_W-1:0];
                REG_END:      r_cfg.end_ms         <= pwdata[PH_W-1:0];
                REG_END_EN:   r_cfg.end_enable     <= pwdata[0];
                REG_NORM:     r_cfg.normalize_time <= pwdata[0];
                REG_LVL_IN:   r_cfg.level_in       <= pwdata[LVL_W-1:0];
                REG_LVL_OUT:  r_cfg.level_out      <= pwdata[LVL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_START:    prdata = DATA_W'(r_cfg.start_ms);
            REG_INTERVAL: prdata = DATA_W'(r_cfg.interval_ms);
            REG_DURATION: prdata = DATA_W'(r_cfg.duration_ms);
            REG_END:      prdata = DATA_W'(r_cfg.end_ms);
            REG_END_EN:   prdata = DATA_W'(r_cfg.end_enable);
            REG_NORM:     prdata = DATA_W'(r_cfg.normalize_time);
            REG_LVL_IN:   prdata = DATA_W'(r_cfg.level_in);
            REG_LVL_OUT:  prdata = DATA_W'(r_cfg.level_out);
            default:      prdata = '0;
        endcase
    end

    ptwg_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_push         (push),
        .i_timestamp_ns (i_timestamp_ns),
        .o_full         (full),
        .o_cmd_push     (w_cmd_push),
        .o_cmd          (w_cmd_in),
        .i_cmd_full     (w_cmd_full)
    );

    ptwg_fifo #(
        .DEPTH (Q_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_cmd_push),
        .i_data  (w_cmd_in),
        .o_full  (w_cmd_full),
        .i_pop   (w_cmd_pop),
        .o_data  (w_cmd_out),
        .o_empty (w_cmd_empty)
    );

    ptwg_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_cmd            (w_cmd_out),
        .i_cmd_empty      (w_cmd_empty),
        .o_cmd_pop        (w_cmd_pop),
        .i_pop            (pop),
        .o_empty          (empty),
        .o_interest       (o_interest),
        .o_timestamp_echo (o_timestamp_echo)
    );

endmodule

`default_nettype wire
